FILE: rtl/core/uart_register_model_defines.svh
// Assertion macros used by the UART register model checker.
`ifndef UART_REGISTER_MODEL_DEFINES_SVH
`define UART_REGISTER_MODEL_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define URM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("urm check failed");

// Next-cycle implication, disabled while reset is held.
`define URM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("urm check failed");

`endif

FILE: rtl/core/urm_pkg.sv
// Package with codes, offsets and constants of the UART register model.
`timescale 1ns / 1ps
`default_nettype none
package urm_pkg;

    localparam int URM_RX_DEPTH = 16;

    typedef enum logic [1:0] {
        FN_READ  = 2'd0,
        FN_WRITE = 2'd1,
        FN_RX    = 2'd2,
        FN_TX    = 2'd3
    } urm_func_t;

    typedef enum logic [1:0] {
        IRQ_NONE     = 2'd0,
        IRQ_ASSERT   = 2'd1,
        IRQ_DEASSERT = 2'd2,
        IRQ_REFRESH  = 2'd3
    } urm_irq_t;

    localparam logic [11:0] OFF_DR   = 12'h000;
    localparam logic [11:0] OFF_FR   = 12'h018;
    localparam logic [11:0] OFF_IBRD = 12'h024;
    localparam logic [11:0] OFF_FBRD = 12'h028;
    localparam logic [11:0] OFF_LCRH = 12'h02C;
    localparam logic [11:0] OFF_CR   = 12'h030;
    localparam logic [11:0] OFF_IFLS = 12'h034;
    localparam logic [11:0] OFF_IMSC = 12'h038;
    localparam logic [11:0] OFF_RIS  = 12'h03C;
    localparam logic [11:0] OFF_MIS  = 12'h040;
    localparam logic [11:0] OFF_ICR  = 12'h044;
    localparam logic [11:0] ID_BASE  = 12'hFE0;

    localparam int BIT_TX = 5;
    localparam int BIT_RX = 4;
    localparam int BIT_RT = 6;

    localparam logic [31:0] FR_TXFE = 32'h0000_0080;
    localparam logic [31:0] FR_TXFF = 32'h0000_0020;
    localparam logic [31:0] FR_RXFE = 32'h0000_0010;
    localparam logic [31:0] FR_BUSY = 32'h0000_0008;

    localparam logic [31:0] CR_RESET   = 32'h0000_0301;
    localparam logic [31:0] IFLS_RESET = 32'h0000_0012;

    function automatic logic [7:0] id_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h11;
            3'd1:    b = 8'h10;
            3'd2:    b = 8'h14;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'hF0;
            3'd6:    b = 8'h05;
            3'd7:    b = 8'hB1;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] raw_bits(input logic tx_flag, input logic rx_nonempty);
        logic [31:0] v;
        v = '0;
        v[BIT_TX] = tx_flag;
        v[BIT_RX] = rx_nonempty;
        v[BIT_RT] = rx_nonempty;
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/urm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module urm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                     wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/uart_register_model.sv
// Top level of the reduced UART register model.
//
//  channel | dir | fields (low bit first)
//  s_      | in  | tuser: func; tdata: offset, access_size, write_data, host_rx_byte, tx_ready
//  m_      | out | tdata: read_data, bad_access, irq_action, irq_line, tx_valid, tx_byte,
//          |     |        rx_dropped
//
// Each item is latched in ST_IDLE while the RX RAM reads the head entry, then
// decoded in ST_EXEC, which updates the registers and loads the output register.
// The idle cycle between items lets a push land in the RAM before the next read.
// A stalled output holds the block in its execute cycle; s_tready is low there.
// aresetn is synchronous, active low; the RX RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module uart_register_model import urm_pkg::*; #(
    parameter int RX_DEPTH = URM_RX_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // offset[11:0], access_size[14:12], write_data[46:15], host_rx_byte[54:47],
    // tx_ready[55]
    input  wire logic [55:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[31:0], bad_access[32], irq_action[34:33], irq_line[35],
    // tx_valid[36], tx_byte[44:37], rx_dropped[45], zero[47:46]
    output logic [47:0]      m_tdata
);

    localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int FW = $clog2(RX_DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(RX_DEPTH - 1);
    localparam logic [FW-1:0] FULL_CNT = FW'(RX_DEPTH);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    typedef struct packed {
        urm_func_t   func;
        logic [11:0] offset;
        logic [2:0]  size;
        logic [31:0] wdata;
        logic [7:0]  rxb;
        logic        ready;
    } item_t;

    state_t      state_reg;
    item_t       item_reg;
    logic        m_tvalid_reg;
    logic [47:0] m_tdata_reg;

    logic [31:0] baud_int_reg, baud_int_next;
    logic [31:0] baud_frac_reg, baud_frac_next;
    logic [31:0] line_ctrl_reg, line_ctrl_next;
    logic [31:0] ctrl_reg, ctrl_next;
    logic [31:0] ifls_reg, ifls_next;
    logic [31:0] mask_reg, mask_next;
    logic        tx_flag_reg, tx_flag_next;
    logic        line_reg, line_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic [7:0]  ram_rdata;
    logic        ram_we;
    logic        commit;
    logic        upd;
    logic        kick;
    logic        want;
    logic        bad;
    logic [31:0] rd;
    urm_irq_t    act;
    logic        txv;
    logic [7:0]  txb;
    logic        drop;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign commit   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    urm_ram #(
        .WIDTH (8),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (tail_reg),
        .wr_data (item_reg.rxb),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    always_comb begin
        baud_int_next  = baud_int_reg;
        baud_frac_next = baud_frac_reg;
        line_ctrl_next = line_ctrl_reg;
        ctrl_next      = ctrl_reg;
        ifls_next      = ifls_reg;
        mask_next      = mask_reg;
        tx_flag_next   = tx_flag_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        ram_we         = 1'b0;
        upd            = 1'b0;
        kick           = 1'b0;
        rd             = '0;
        txv            = 1'b0;
        txb            = '0;
        drop           = 1'b0;

        bad = ((item_reg.func == FN_READ) || (item_reg.func == FN_WRITE)) &&
              !((item_reg.size == 3'd1) || (item_reg.size == 3'd2) || (item_reg.size == 3'd4));

        case (item_reg.func)
            FN_READ: begin
                if (!bad) begin
                    case (item_reg.offset)
                        OFF_DR: begin
                            if (fill_reg != '0) begin
                                rd        = {24'h0, ram_rdata};
                                head_next = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
                                fill_next = fill_reg - FW'(1);
                            end
                            upd = 1'b1;
                        end
                        OFF_FR: begin
                            rd = item_reg.ready ? FR_TXFE : (FR_TXFF | FR_BUSY);
                            if (fill_reg == '0) begin
                                rd = rd | FR_RXFE;
                            end
                        end
                        OFF_IBRD: rd = baud_int_reg;
                        OFF_FBRD: rd = baud_frac_reg;
                        OFF_LCRH: rd = line_ctrl_reg;
                        OFF_CR:   rd = ctrl_reg;
                        OFF_IFLS: rd = ifls_reg;
                        OFF_IMSC: rd = mask_reg;
                        OFF_RIS: begin
                            rd  = raw_bits(tx_flag_reg, fill_reg != '0);
                            upd = 1'b1;
                        end
                        OFF_MIS: begin
                            rd  = raw_bits(tx_flag_reg, fill_reg != '0) & mask_reg;
                            upd = 1'b1;
                        end
                        default: begin
                            if (item_reg.offset >= ID_BASE) begin
                                rd = {24'h0, id_byte(item_reg.offset[4:2])};
                            end
                        end
                    endcase
                end
            end
            FN_WRITE: begin
                if (!bad) begin
                    upd = 1'b1;
                    case (item_reg.offset)
                        OFF_DR: begin
                            txv          = 1'b1;
                            txb          = item_reg.wdata[7:0];
                            tx_flag_next = item_reg.ready;
                            upd          = (tx_flag_reg != item_reg.ready) && mask_reg[BIT_TX];
                        end
                        OFF_IBRD: baud_int_next  = item_reg.wdata;
                        OFF_FBRD: baud_frac_next = item_reg.wdata;
                        OFF_LCRH: line_ctrl_next = item_reg.wdata;
                        OFF_CR:   ctrl_next      = item_reg.wdata;
                        OFF_IFLS: ifls_next      = item_reg.wdata;
                        OFF_IMSC: begin
                            if (!mask_reg[BIT_TX] && item_reg.wdata[BIT_TX]) begin
                                tx_flag_next = item_reg.ready;
                            end
                            mask_next = item_reg.wdata;
                        end
                        OFF_ICR: begin
                            if (item_reg.wdata[BIT_TX]) begin
                                tx_flag_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FN_RX: begin
                if (fill_reg >= FULL_CNT) begin
                    drop = 1'b1;
                end else begin
                    ram_we    = commit;
                    tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);
                    fill_next = fill_reg + FW'(1);
                    upd       = 1'b1;
                    kick      = 1'b1;
                end
            end
            FN_TX: begin
                tx_flag_next = item_reg.ready;
                upd          = (tx_flag_reg != item_reg.ready);
                kick         = 1'b1;
            end
            default: ;
        endcase

        want      = (raw_bits(tx_flag_next, fill_next != '0) & mask_next) != '0;
        line_next = line_reg;
        act       = IRQ_NONE;
        if (upd) begin
            if (want && !line_reg) begin
                line_next = 1'b1;
                act       = IRQ_ASSERT;
            end else if (want) begin
                act = kick ? IRQ_ASSERT : IRQ_REFRESH;
            end else if (line_reg) begin
                line_next = 1'b0;
                act       = IRQ_DEASSERT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            baud_int_reg  <= '0;
            baud_frac_reg <= '0;
            line_ctrl_reg <= '0;
            ctrl_reg      <= CR_RESET;
            ifls_reg      <= IFLS_RESET;
            mask_reg      <= '0;
            tx_flag_reg   <= 1'b0;
            line_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
        end else begin
            if (m_tvalid_reg && m_tready && !commit) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        item_reg.func   <= urm_func_t'(s_tuser);
                        item_reg.offset <= s_tdata[11:0];
                        item_reg.size   <= s_tdata[14:12];
                        item_reg.wdata  <= s_tdata[46:15];
                        item_reg.rxb    <= s_tdata[54:47];
                        item_reg.ready  <= s_tdata[55];
                        state_reg       <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (commit) begin
                        baud_int_reg  <= baud_int_next;
                        baud_frac_reg <= baud_frac_next;
                        line_ctrl_reg <= line_ctrl_next;
                        ctrl_reg      <= ctrl_next;
                        ifls_reg      <= ifls_next;
                        mask_reg      <= mask_next;
                        tx_flag_reg   <= tx_flag_next;
                        line_reg      <= line_next;
                        head_reg      <= head_next;
                        tail_reg      <= tail_next;
                        fill_reg      <= fill_next;
                        m_tvalid_reg  <= 1'b1;
                        m_tdata_reg   <= {2'b00, drop, txb, txv, line_next, act, bad, rd};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/urm_checker.sv
// Port-level checker for the UART register model, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_register_model_defines.svh"
module urm_checker import urm_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [55:0] s_tdata,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    logic        s_xfer;
    logic        s_wait;
    logic        m_wait;
    logic [31:0] m_rd;
    logic        m_bad;
    logic [1:0]  m_act;
    logic        m_line;
    logic        m_txv;
    logic        m_raise;

    assign s_xfer  = s_tvalid && s_tready;
    assign s_wait  = s_tvalid && !s_tready;
    assign m_wait  = m_tvalid && !m_tready;
    assign m_rd    = m_tdata[31:0];
    assign m_bad   = m_tdata[32];
    assign m_act   = m_tdata[34:33];
    assign m_line  = m_tdata[35];
    assign m_txv   = m_tdata[36];
    assign m_raise = (m_act == IRQ_ASSERT) || (m_act == IRQ_REFRESH);

    `URM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_wait, m_tvalid && $stable(m_tdata))
    `URM_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_wait, s_tvalid && $stable({s_tuser, s_tdata}))
    `URM_ASSERT_NOW(a_bad_quiet, aclk, aresetn, m_tvalid && m_bad, (m_act == IRQ_NONE) && !m_txv && (m_rd == '0))
    `URM_ASSERT_NOW(a_irq_level, aclk, aresetn, m_tvalid && m_raise, m_line)
    `URM_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_xfer, !s_tready)

endmodule

bind uart_register_model urm_checker u_urm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

FILE: tb/uart_register_model_tb.sv
// Self-checking testbench for the UART register model: directed and random stream traffic.
`timescale 1ns / 1ps
module uart_register_model_tb import urm_pkg::*;;

    localparam int RANDOM_ITEMS = 2000;
    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 50;
    localparam logic [7:0] ID_BYTES [8] = '{8'h11, 8'h10, 8'h14, 8'h00,
                                            8'h0D, 8'hF0, 8'h05, 8'hB1};

    typedef struct {
        urm_func_t   func;
        logic [11:0] offset;
        logic [2:0]  acc_size;
        logic [31:0] wdata;
        logic [7:0]  rx_byte;
        logic        ready;
    } stim_t;

    typedef struct {
        logic [31:0] read_data;
        logic        bad_access;
        urm_irq_t    irq_action;
        logic        irq_line;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        rx_dropped;
    } result_t;

    typedef struct {
        stim_t   st;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // register shadow
    logic [31:0] sh_ibrd = '0;
    logic [31:0] sh_fbrd = '0;
    logic [31:0] sh_lcrh = '0;
    logic [31:0] sh_cr   = CR_RESET;
    logic [31:0] sh_ifls = IFLS_RESET;
    logic [31:0] sh_imsc = '0;
    logic        sh_tx_raw = 1'b0;
    logic        sh_line_high = 1'b0;
    logic [7:0]  sh_fifo [URM_RX_DEPTH];
    int          sh_head = 0;
    int          sh_tail = 0;
    int          sh_fill = 0;

    result_t  pending_results[$];
    dir_row_t dir_rows[$];
    bit       tx_steady = 1'b0;
    bit       rx_steady = 1'b0;
    int       cycles = 0;
    int       n_items = 0, n_checked = 0, n_errors = 0;
    int       n_reads = 0, n_writes = 0, n_rx = 0, n_txev = 0, n_bad = 0, n_dropped = 0;
    int       n_assert = 0, n_refresh = 0, n_deassert = 0;

    uart_register_model uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic logic [31:0] raw_now();
        logic [31:0] v;
        v = '0;
        v[BIT_TX] = sh_tx_raw;
        v[BIT_RX] = (sh_fill != 0);
        v[BIT_RT] = (sh_fill != 0);
        return v;
    endfunction

    function automatic urm_irq_t irq_update(input logic kick);
        logic want_high;
        want_high = (raw_now() & sh_imsc) != 0;
        if (want_high && !sh_line_high) begin
            sh_line_high = 1'b1;
            return IRQ_ASSERT;
        end
        if (want_high) begin
            return kick ? IRQ_ASSERT : IRQ_REFRESH;
        end
        if (sh_line_high) begin
            sh_line_high = 1'b0;
            return IRQ_DEASSERT;
        end
        return IRQ_NONE;
    endfunction

    task automatic predict_uart(input stim_t s, output result_t r);
        logic        upd;
        logic        old_flag;
        logic [11:0] id_off;
        r.read_data  = '0;
        r.bad_access = 1'b0;
        r.irq_action = IRQ_NONE;
        r.tx_valid   = 1'b0;
        r.tx_byte    = '0;
        r.rx_dropped = 1'b0;
        upd = 1'b0;
        if ((s.func == FN_READ || s.func == FN_WRITE) &&
            !(s.acc_size == 3'd1 || s.acc_size == 3'd2 || s.acc_size == 3'd4)) begin
            r.bad_access = 1'b1;
            n_bad++;
        end else begin
            case (s.func)
                FN_READ: begin
                    n_reads++;
                    case (s.offset)
                        OFF_DR: begin
                            if (sh_fill != 0) begin
                                r.read_data = {24'd0, sh_fifo[sh_head]};
                                sh_head = (sh_head + 1) % URM_RX_DEPTH;
                                sh_fill--;
                            end
                            upd = 1'b1;
                        end
                        OFF_FR: begin
                            r.read_data = s.ready ? FR_TXFE : (FR_TXFF | FR_BUSY);
                            if (sh_fill == 0) r.read_data = r.read_data | FR_RXFE;
                        end
                        OFF_IBRD: r.read_data = sh_ibrd;
                        OFF_FBRD: r.read_data = sh_fbrd;
                        OFF_LCRH: r.read_data = sh_lcrh;
                        OFF_CR:   r.read_data = sh_cr;
                        OFF_IFLS: r.read_data = sh_ifls;
                        OFF_IMSC: r.read_data = sh_imsc;
                        OFF_RIS: begin
                            r.read_data = raw_now();
                            upd = 1'b1;
                        end
                        OFF_MIS: begin
                            r.read_data = raw_now() & sh_imsc;
                            upd = 1'b1;
                        end
                        default: begin
                            if (s.offset >= ID_BASE) begin
                                id_off = s.offset - ID_BASE;
                                r.read_data = {24'd0, ID_BYTES[id_off[4:2]]};
                            end
                        end
                    endcase
                    if (upd) r.irq_action = irq_update(1'b0);
                end
                FN_WRITE: begin
                    n_writes++;
                    upd = 1'b1;
                    case (s.offset)
                        OFF_DR: begin
                            old_flag = sh_tx_raw;
                            r.tx_valid = 1'b1;
                            r.tx_byte = s.wdata[7:0];
                            sh_tx_raw = s.ready;
                            upd = (old_flag != sh_tx_raw) && sh_imsc[BIT_TX];
                        end
                        OFF_IBRD: sh_ibrd = s.wdata;
                        OFF_FBRD: sh_fbrd = s.wdata;
                        OFF_LCRH: sh_lcrh = s.wdata;
                        OFF_CR:   sh_cr   = s.wdata;
                        OFF_IFLS: sh_ifls = s.wdata;
                        OFF_IMSC: begin
                            if (!sh_imsc[BIT_TX] && s.wdata[BIT_TX]) sh_tx_raw = s.ready;
                            sh_imsc = s.wdata;
                        end
                        OFF_ICR: begin
                            if (s.wdata[BIT_TX]) sh_tx_raw = 1'b0;
                        end
                        default: ;
                    endcase
                    if (upd) r.irq_action = irq_update(1'b0);
                end
                FN_RX: begin
                    n_rx++;
                    if (sh_fill >= URM_RX_DEPTH) begin
                        r.rx_dropped = 1'b1;
                        n_dropped++;
                    end else begin
                        sh_fifo[sh_tail] = s.rx_byte;
                        sh_tail = (sh_tail + 1) % URM_RX_DEPTH;
                        sh_fill++;
                        r.irq_action = irq_update(1'b1);
                    end
                end
                default: begin
                    n_txev++;
                    old_flag = sh_tx_raw;
                    sh_tx_raw = s.ready;
                    if (old_flag != sh_tx_raw) r.irq_action = irq_update(1'b1);
                end
            endcase
        end
        case (r.irq_action)
            IRQ_ASSERT:   n_assert++;
            IRQ_REFRESH:  n_refresh++;
            IRQ_DEASSERT: n_deassert++;
            default: ;
        endcase
        r.irq_line = sh_line_high;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("mismatch at result %0d: %s got 0x%08h, want 0x%08h",
                     n_checked, field, got, want);
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        n_checked++;
        if (pending_results.size() == 0) begin
            report_mismatch("no result pending", got.read_data, 32'd0);
        end else begin
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", got.read_data, want.read_data);
            if (got.bad_access !== want.bad_access)
                report_mismatch("bad_access", 32'(got.bad_access), 32'(want.bad_access));
            if (got.irq_action !== want.irq_action)
                report_mismatch("irq_action", 32'(got.irq_action), 32'(want.irq_action));
            if (got.irq_line !== want.irq_line)
                report_mismatch("irq_line", 32'(got.irq_line), 32'(want.irq_line));
            if (got.tx_valid !== want.tx_valid)
                report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
            if (got.tx_byte !== want.tx_byte)
                report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
            if (got.rx_dropped !== want.rx_dropped)
                report_mismatch("rx_dropped", 32'(got.rx_dropped), 32'(want.rx_dropped));
        end
    endtask

    function automatic stim_t mk_stim(input urm_func_t f, input logic [11:0] off,
                                      input logic [2:0] sz, input logic [31:0] wd,
                                      input logic [7:0] rxb, input logic rdy);
        stim_t s;
        s.func = f;
        s.offset = off;
        s.acc_size = sz;
        s.wdata = wd;
        s.rx_byte = rxb;
        s.ready = rdy;
        return s;
    endfunction

    function automatic result_t mk_res(input logic [31:0] rd, input logic bad,
                                       input urm_irq_t act, input logic lvl,
                                       input logic txv, input logic [7:0] txb);
        result_t r;
        r.read_data = rd;
        r.bad_access = bad;
        r.irq_action = act;
        r.irq_line = lvl;
        r.tx_valid = txv;
        r.tx_byte = txb;
        r.rx_dropped = 1'b0;
        return r;
    endfunction

    task automatic add_row(input stim_t s, input bit typed, input result_t want);
        dir_row_t row;
        row.st = s;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    function automatic logic [2:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 3'd1;
        if (r < 6) return 3'd2;
        if (r < 9) return 3'd4;
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [11:0] pick_offset();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:  return OFF_DR;
            1:  return OFF_FR;
            2:  return OFF_IBRD;
            3:  return OFF_FBRD;
            4:  return OFF_LCRH;
            5:  return OFF_CR;
            6:  return OFF_IFLS;
            7:  return OFF_IMSC;
            8:  return OFF_RIS;
            9:  return OFF_MIS;
            10: return OFF_ICR;
            11, 12: return ID_BASE + 12'($urandom_range(0, 31));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic stim_t rand_stim(input urm_func_t f, input logic [11:0] off);
        return mk_stim(f, off, pick_size(), $urandom, 8'($urandom), 1'($urandom));
    endfunction

    task automatic send_item(input stim_t s, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= s.func;
        s_tdata  <= {s.ready, s.rx_byte, s.wdata, s.acc_size, s.offset};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_uart(s, predicted);
        pending_results.push_back(typed ? want : predicted);
        n_items++;
        @(negedge aclk);
    endtask

    // result side: random stalls, check every transfer
    initial begin
        int      stall;
        int      mode_left;
        result_t got;
        mode_left = 0;
        m_tready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (mode_left == 0) begin
                rx_steady = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            stall = rx_steady ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.read_data  = m_tdata[31:0];
            got.bad_access = m_tdata[32];
            got.irq_action = urm_irq_t'(m_tdata[34:33]);
            got.irq_line   = m_tdata[35];
            got.tx_valid   = m_tdata[36];
            got.tx_byte    = m_tdata[44:37];
            got.rx_dropped = m_tdata[45];
            check_result(got);
            @(negedge aclk);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d results pending",
                         cycles, pending_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        result_t no_res;
        stim_t   s;
        no_res = mk_res(32'd0, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0);

        // reset values, FR, empty DR, ID window
        add_row(mk_stim(FN_READ, OFF_CR, 3'd4, '0, '0, 1'b1), 1'b1,
                mk_res(CR_RESET, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_READ, OFF_IFLS, 3'd2, '0, '0, 1'b1), 1'b1,
                mk_res(IFLS_RESET, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_READ, OFF_DR, 3'd1, '0, '0, 1'b1), 1'b1, no_res);
        add_row(mk_stim(FN_READ, OFF_FR, 3'd4, '0, '0, 1'b1), 1'b1,
                mk_res(FR_TXFE | FR_RXFE, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_READ, OFF_FR, 3'd4, '0, '0, 1'b0), 1'b1,
                mk_res(FR_TXFF | FR_BUSY | FR_RXFE, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_READ, 12'hFE0, 3'd4, '0, '0, 1'b0), 1'b1,
                mk_res(32'h11, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_READ, 12'hFFF, 3'd1, '0, '0, 1'b0), 1'b1,
                mk_res(32'hB1, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_READ, 12'hFE6, 3'd2, '0, '0, 1'b0), 1'b1,
                mk_res(32'h10, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        // illegal sizes
        add_row(mk_stim(FN_READ, OFF_IBRD, 3'd0, '0, '0, 1'b1), 1'b1,
                mk_res(32'd0, 1'b1, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_WRITE, OFF_CR, 3'd3, '1, '1, 1'b1), 1'b1,
                mk_res(32'd0, 1'b1, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_WRITE, OFF_DR, 3'd7, '1, '1, 1'b1), 1'b1,
                mk_res(32'd0, 1'b1, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        // register write/readback at the extremes
        add_row(mk_stim(FN_WRITE, OFF_IBRD, 3'd1, '1, '0, 1'b0), 1'b1, no_res);
        add_row(mk_stim(FN_READ, OFF_IBRD, 3'd4, '0, '0, 1'b0), 1'b1,
                mk_res(32'hFFFF_FFFF, 1'b0, IRQ_NONE, 1'b0, 1'b0, 8'd0));
        add_row(mk_stim(FN_WRITE, OFF_DR, 3'd4, 32'h0000_01FF, '0, 1'b1), 1'b1,
                mk_res(32'd0, 1'b0, IRQ_NONE, 1'b0, 1'b1, 8'hFF));
        // interrupt path
        add_row(mk_stim(FN_WRITE, OFF_IMSC, 3'd4, 32'h70, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_READ, OFF_RIS, 3'd4, '0, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_RX, OFF_DR, 3'd0, '0, 8'h5A, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_READ, OFF_MIS, 3'd4, '0, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_WRITE, OFF_ICR, 3'd4, 32'h20, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_READ, OFF_DR, 3'd1, '0, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_TX, OFF_DR, 3'd5, '0, '0, 1'b0), 1'b0, no_res);
        add_row(mk_stim(FN_TX, OFF_DR, 3'd6, '0, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_WRITE, 12'h100, 3'd2, '1, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_READ, 12'h7FC, 3'd4, '0, '0, 1'b1), 1'b0, no_res);
        add_row(mk_stim(FN_WRITE, OFF_IMSC, 3'd4, 32'h0, '0, 1'b0), 1'b0, no_res);

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].st, dir_rows[i].typed, dir_rows[i].want);

        while (n_items - n_bad < RANDOM_ITEMS + dir_rows.size()) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 8)) begin
                        s = rand_stim(urm_func_t'($urandom_range(0, 1)), pick_offset());
                        send_item(s, 1'b0, no_res);
                    end
                end
                4: begin
                    repeat ($urandom_range(8, 20)) begin
                        s = rand_stim(FN_RX, 12'($urandom));
                        send_item(s, 1'b0, no_res);
                    end
                end
                5: begin
                    repeat ($urandom_range(1, 18)) begin
                        s = rand_stim(FN_READ, OFF_DR);
                        send_item(s, 1'b0, no_res);
                    end
                end
                6: begin
                    repeat ($urandom_range(1, 6)) begin
                        s = rand_stim(FN_TX, 12'($urandom));
                        send_item(s, 1'b0, no_res);
                    end
                end
                7: begin
                    s = rand_stim(FN_WRITE, OFF_IMSC);
                    send_item(s, 1'b0, no_res);
                    s = rand_stim(FN_WRITE, OFF_ICR);
                    send_item(s, 1'b0, no_res);
                end
                8: begin
                    repeat ($urandom_range(1, 6)) begin
                        s = rand_stim(FN_WRITE, OFF_DR);
                        send_item(s, 1'b0, no_res);
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 4)) begin
                        s = rand_stim(urm_func_t'($urandom_range(0, 3)), 12'($urandom));
                        s.acc_size = 3'($urandom);
                        send_item(s, 1'b0, no_res);
                    end
                end
            endcase
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("covered %0d transfers: %0d reads, %0d writes, %0d rx bytes (%0d dropped),",
                 n_items, n_reads, n_writes, n_rx, n_dropped);
        $display("  %0d tx events, %0d bad sizes; irq assert %0d refresh %0d deassert %0d",
                 n_txev, n_bad, n_assert, n_refresh, n_deassert);
        if (n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
